// ===== sv/buddy_bitmap_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Buddy bitmap allocator assertion macros
// Immediate-consequence and next-cycle property wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BITMAP_ALLOCATOR_MACROS_SVH
`define BUDDY_BITMAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Consequence holds in the same cycle as the antecedent
`define BBA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bba: same-cycle check failed");
// Consequence holds in the cycle after the antecedent
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bba: next-cycle check failed");
`else
`define BBA_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy bitmap allocator package
// Field widths, result codes, register indexes, controller states and the
// command and status types between controller and datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned SIZE_W      = 24;
  localparam int unsigned NODE_W      = 10;
  localparam int unsigned LEVEL_W     = 4;
  localparam int unsigned OFFSET_W    = 26;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned MIN_BLOCK_W = 16;
  localparam int unsigned POOL_W      = 25;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 25;

  localparam logic [POOL_W-1:0]      HEADER_BYTES    = 25'd4;
  localparam logic [MIN_BLOCK_W-1:0] MIN_BLOCK_RESET = 16'd16;
  localparam logic [POOL_W-1:0]      POOL_RESET      = 25'd8192;
  localparam logic [LEVEL_W-1:0]     LEVELS_RESET    = 4'd9;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS    = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED    = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_NO_FREE      = 3'd2,
    ST_FREED        = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ACHK, S_LVL, S_SRD, S_SEV, S_TRD, S_TWR,
    S_AINIT, S_ATEST, S_AWR, S_AUP, S_RES, S_FTST,
    S_MTST, S_MRD, S_MEV, S_PRD, S_PWR, S_OUT
  } state_e;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_CLR, CMD_START, CMD_LSTEP, CMD_SCAN_INIT, CMD_RD,
    CMD_ROW_INC, CMD_SCAN_HIT, CMD_WR_RANGE, CMD_WR_ONE, CMD_ANC_INIT,
    CMD_ANC_UP, CMD_MUL, CMD_RES_ALLOC, CMD_RES_TOO_LARGE, CMD_RES_NO_FREE,
    CMD_RES_FREED, CMD_RES_ALREADY, CMD_BUDDY, CMD_PARENT
  } cmd_e;

  typedef struct packed {
    logic clear_done;
    logic is_free;
    logic fits;
    logic idx_bad;
    logic lvl_done;
    logic scan_hit;
    logic scan_last;
    logic range_done;
    logic anc_done;
    logic bit_busy;
    logic at_root;
  } dp_stat_t;

endpackage

// ===== sv/bba_intf.sv =====
// ----------------------------------------------------------------------------
// Buddy bitmap allocator channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bba_req_if;
  import bba_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [SIZE_W-1:0]   request_size;
  logic [NODE_W-1:0]   free_node;
  modport source (output valid, kind, request_size, free_node, input ready);
  modport sink   (input valid, kind, request_size, free_node, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NODE_W-1:0]   node_index;
  logic [LEVEL_W-1:0]  block_level;
  logic [OFFSET_W-1:0] payload_offset;
  modport source (output valid, status, node_index, block_level, payload_offset,
                  input ready);
  modport sink   (input valid, status, node_index, block_level, payload_offset,
                  output ready);
endinterface

interface bba_cfg_if;
  import bba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/bba_datapath.sv =====
// ----------------------------------------------------------------------------
// Buddy bitmap allocator datapath
// Configuration registers, the busy-bit memory in 32-bit rows, range masks,
// first-free search, level search and offset multiply, driven by commands.
// ----------------------------------------------------------------------------
module bba_datapath #(
  parameter int unsigned MAX_DEPTH = 9
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bba_pkg::cmd_e                     cmd_i,
  output bba_pkg::dp_stat_t                 stat_o,
  input  logic                              cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bba_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              kind_i,
  input  logic [bba_pkg::SIZE_W-1:0]        request_size_i,
  input  logic [bba_pkg::NODE_W-1:0]        free_node_i,
  output logic [bba_pkg::STATUS_W-1:0]      status_o,
  output logic [bba_pkg::NODE_W-1:0]        node_index_o,
  output logic [bba_pkg::LEVEL_W-1:0]       block_level_o,
  output logic [bba_pkg::OFFSET_W-1:0]      payload_offset_o
);
  import bba_pkg::*;

  // Node positions are 1-based: level k spans [2^k, 2^(k+1)-1]
  localparam int unsigned PW    = MAX_DEPTH + 1;
  localparam int unsigned RB    = (PW >= 5) ? 5 : PW;
  localparam int unsigned ROW_W = 1 << RB;
  localparam int unsigned RAW   = (PW > RB) ? PW - RB : 1;
  localparam int unsigned ROWS  = 1 << (PW - RB);
  localparam int unsigned XW    = RAW + RB;
  localparam int unsigned BSW   = MIN_BLOCK_W + MAX_DEPTH;
  localparam int unsigned CW    = (BSW > POOL_W) ? BSW : POOL_W;

  function automatic logic [LEVEL_W-1:0] node_lvl(input logic [NODE_W:0] pos);
    logic [LEVEL_W-1:0] l;
    l = '0;
    for (int b = 1; b <= NODE_W; b++) begin
      if (pos[b]) l = LEVEL_W'(b);
    end
    return l;
  endfunction

  logic [MIN_BLOCK_W-1:0] min_blk_q;
  logic [POOL_W-1:0]      pool_q;
  logic [LEVEL_W-1:0]     levels_q;
  logic [RAW-1:0]         row_q, row_d;

  logic                   kind_q;
  logic [POOL_W-1:0]      need_q;
  logic [NODE_W-1:0]      idx_q;
  logic [LEVEL_W-1:0]     flev_q, dep_q, lev_q, cnt_q;
  logic [BSW-1:0]         bsize_q;
  logic [XW-1:0]          p_q, lo_q, hi_q;
  logic [ROW_W-1:0]       rd_q;
  logic [XW+BSW-1:0]      prod_q;
  status_e                res_status_q;
  logic [NODE_W-1:0]      res_node_q;
  logic [LEVEL_W-1:0]     res_lev_q;
  logic [OFFSET_W-1:0]    res_off_q;

  logic [ROW_W-1:0]       mem [ROWS];

  logic [ROW_W-1:0]       mask, cand, wr_data;
  logic [RB-1:0]          hit_pos;
  logic [XW-1:0]          pos_b, hit_node, lo_next, scan_lo, scan_hi, par, bud, anc;
  logic [POOL_W-1:0]      need_in;
  logic [NODE_W:0]        p_in, p_idx;
  logic [XW-1:0]          p_in_x;
  logic [LEVEL_W-1:0]     dep_in, flev_in;
  logic                   last_row, more_lvl;
  logic [XW-1:0]          diff;

  // Work out range mask for the current row and the first free bit in it
  always_comb begin
    mask    = '0;
    hit_pos = '0;
    pos_b   = '0;
    for (int b = 0; b < ROW_W; b++) begin
      pos_b   = {row_q, RB'(b)};
      mask[b] = (pos_b >= lo_q) && (pos_b <= hi_q);
    end
    cand = ~rd_q & mask;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (cand[b]) hit_pos = RB'(b);
    end
  end

  assign wr_data  = (rd_q & ~mask) | ((kind_q == KIND_ALLOC) ? mask : '0);
  assign hit_node = {row_q, hit_pos};
  assign last_row = (row_q == hi_q[XW-1:RB]);
  assign more_lvl = ({1'b0, lev_q} + {1'b0, cnt_q}) < {1'b0, dep_q};
  assign lo_next  = lo_q << 1;
  assign scan_lo  = XW'(1) << lev_q;
  assign scan_hi  = (XW'(2) << lev_q) - XW'(1);
  assign par      = p_q >> 1;
  assign bud      = p_q ^ XW'(1);
  assign anc      = lo_q >> 1;
  assign diff     = p_q - scan_lo;

  assign need_in  = POOL_W'(request_size_i) + HEADER_BYTES;
  assign p_in     = (NODE_W + 1)'(free_node_i) + (NODE_W + 1)'(1);
  assign p_in_x   = XW'(p_in);
  assign p_idx    = (NODE_W + 1)'(idx_q) + (NODE_W + 1)'(1);
  assign dep_in   = (levels_q > LEVEL_W'(MAX_DEPTH)) ? LEVEL_W'(MAX_DEPTH) : levels_q;
  assign flev_in  = node_lvl(p_in);

  // Status back to the controller
  always_comb begin
    stat_o.clear_done = (row_q == RAW'(ROWS - 1));
    stat_o.is_free    = (kind_q == KIND_FREE);
    stat_o.fits       = !(pool_q < need_q);
    stat_o.idx_bad    = (p_idx >> ({1'b0, dep_q} + 5'd1)) != '0;
    stat_o.lvl_done   = !((cnt_q < dep_q) && (CW'(bsize_q) < CW'(need_q)));
    stat_o.scan_hit   = |cand;
    stat_o.scan_last  = last_row;
    stat_o.range_done = last_row && !more_lvl;
    stat_o.anc_done   = (lo_q == '0);
    stat_o.bit_busy   = |(rd_q & mask);
    stat_o.at_root    = (p_q == XW'(1));
  end

  // Select next row address
  always_comb begin
    row_d = row_q;
    case (cmd_i)
      CMD_CLR, CMD_ROW_INC: row_d = row_q + RAW'(1);
      CMD_START:            row_d = p_in_x[XW-1:RB];
      CMD_SCAN_INIT:        row_d = scan_lo[XW-1:RB];
      CMD_WR_RANGE: begin
        if (!last_row)     row_d = row_q + RAW'(1);
        else if (more_lvl) row_d = lo_next[XW-1:RB];
      end
      CMD_ANC_INIT, CMD_PARENT: row_d = par[XW-1:RB];
      CMD_ANC_UP:               row_d = anc[XW-1:RB];
      CMD_BUDDY:                row_d = bud[XW-1:RB];
      default: ;
    endcase
  end

  // Hold configuration and the row pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_blk_q <= MIN_BLOCK_RESET;
      pool_q    <= POOL_RESET;
      levels_q  <= LEVELS_RESET;
      row_q     <= '0;
    end else begin
      row_q <= row_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_BLOCK: min_blk_q <= cfg_data_i[MIN_BLOCK_W-1:0];
          REG_POOL:      pool_q    <= cfg_data_i[POOL_W-1:0];
          REG_LEVELS:    levels_q  <= cfg_data_i[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Busy-bit memory: one row written or read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_CLR) begin
      mem[row_q] <= '0;
    end else if (cmd_i == CMD_WR_RANGE || cmd_i == CMD_WR_ONE) begin
      mem[row_q] <= wr_data;
    end
    if (cmd_i == CMD_RD) begin
      rd_q <= mem[row_q];
    end
  end

  // Advance working registers per command
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_START: begin
        kind_q  <= kind_i;
        need_q  <= need_in;
        idx_q   <= free_node_i;
        flev_q  <= flev_in;
        dep_q   <= dep_in;
        lev_q   <= (kind_i == KIND_FREE) ? flev_in : dep_in;
        cnt_q   <= '0;
        bsize_q <= BSW'(min_blk_q);
        p_q     <= p_in_x;
        lo_q    <= p_in_x;
        hi_q    <= p_in_x;
      end
      CMD_LSTEP: begin
        bsize_q <= bsize_q << 1;
        lev_q   <= lev_q - LEVEL_W'(1);
        cnt_q   <= cnt_q + LEVEL_W'(1);
      end
      CMD_SCAN_INIT: begin
        lo_q  <= scan_lo;
        hi_q  <= scan_hi;
        cnt_q <= '0;
      end
      CMD_SCAN_HIT: begin
        p_q  <= hit_node;
        lo_q <= hit_node;
        hi_q <= hit_node;
      end
      CMD_WR_RANGE: begin
        if (last_row && more_lvl) begin
          lo_q  <= lo_next;
          hi_q  <= (hi_q << 1) | XW'(1);
          cnt_q <= cnt_q + LEVEL_W'(1);
        end
      end
      CMD_ANC_INIT: begin
        lo_q <= par;
        hi_q <= par;
      end
      CMD_ANC_UP: begin
        lo_q <= anc;
        hi_q <= anc;
      end
      CMD_BUDDY: begin
        lo_q <= bud;
        hi_q <= bud;
      end
      CMD_PARENT: begin
        p_q  <= par;
        lo_q <= par;
        hi_q <= par;
      end
      CMD_MUL: prod_q <= diff * bsize_q;
      CMD_RES_ALLOC: begin
        res_status_q <= ST_ALLOCATED;
        res_node_q   <= NODE_W'(p_q - XW'(1));
        res_lev_q    <= lev_q;
        res_off_q    <= prod_q[OFFSET_W-1:0] + OFFSET_W'(HEADER_BYTES);
      end
      CMD_RES_TOO_LARGE, CMD_RES_NO_FREE: begin
        res_status_q <= (cmd_i == CMD_RES_TOO_LARGE) ? ST_TOO_LARGE : ST_NO_FREE;
        res_node_q   <= '0;
        res_lev_q    <= '0;
        res_off_q    <= '0;
      end
      CMD_RES_FREED, CMD_RES_ALREADY: begin
        res_status_q <= (cmd_i == CMD_RES_FREED) ? ST_FREED : ST_ALREADY_FREE;
        res_node_q   <= idx_q;
        res_lev_q    <= flev_q;
        res_off_q    <= '0;
      end
      default: ;
    endcase
  end

  assign status_o         = res_status_q;
  assign node_index_o     = res_node_q;
  assign block_level_o    = res_lev_q;
  assign payload_offset_o = res_off_q;

endmodule

// ===== sv/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Buddy bitmap allocator controller
// Sequences clearing, level search, row scan, subtree marking, ancestor
// marking and buddy merging through datapath commands.
// ----------------------------------------------------------------------------
`include "buddy_bitmap_allocator_macros.svh"

module bba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  input  bba_pkg::dp_stat_t  stat_i,
  output bba_pkg::cmd_e      cmd_o
);
  import bba_pkg::*;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NOP;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o = CMD_CLR;
        if (stat_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o   = CMD_START;
          state_d = S_ACHK;
        end
      end
      S_ACHK: begin
        if (stat_i.is_free) begin
          if (stat_i.idx_bad) begin
            cmd_o   = CMD_RES_ALREADY;
            state_d = S_OUT;
          end else begin
            cmd_o   = CMD_RD;
            state_d = S_FTST;
          end
        end else if (!stat_i.fits) begin
          cmd_o   = CMD_RES_TOO_LARGE;
          state_d = S_OUT;
        end else begin
          state_d = S_LVL;
        end
      end
      S_LVL: begin
        if (stat_i.lvl_done) begin
          cmd_o   = CMD_SCAN_INIT;
          state_d = S_SRD;
        end else begin
          cmd_o = CMD_LSTEP;
        end
      end
      S_SRD: begin
        cmd_o   = CMD_RD;
        state_d = S_SEV;
      end
      S_SEV: begin
        if (stat_i.scan_hit) begin
          cmd_o   = CMD_SCAN_HIT;
          state_d = S_TRD;
        end else if (stat_i.scan_last) begin
          cmd_o   = CMD_RES_NO_FREE;
          state_d = S_OUT;
        end else begin
          cmd_o   = CMD_ROW_INC;
          state_d = S_SRD;
        end
      end
      S_TRD: begin
        cmd_o   = CMD_RD;
        state_d = S_TWR;
      end
      S_TWR: begin
        cmd_o = CMD_WR_RANGE;
        if (stat_i.range_done) begin
          state_d = stat_i.is_free ? S_MTST : S_AINIT;
        end else begin
          state_d = S_TRD;
        end
      end
      S_AINIT: begin
        cmd_o   = CMD_ANC_INIT;
        state_d = S_ATEST;
      end
      S_ATEST: begin
        if (stat_i.anc_done) begin
          cmd_o   = CMD_MUL;
          state_d = S_RES;
        end else begin
          cmd_o   = CMD_RD;
          state_d = S_AWR;
        end
      end
      S_AWR: begin
        cmd_o   = CMD_WR_ONE;
        state_d = S_AUP;
      end
      S_AUP: begin
        cmd_o   = CMD_ANC_UP;
        state_d = S_ATEST;
      end
      S_RES: begin
        cmd_o   = CMD_RES_ALLOC;
        state_d = S_OUT;
      end
      S_FTST: begin
        if (stat_i.bit_busy) begin
          state_d = S_TWR;
        end else begin
          cmd_o   = CMD_RES_ALREADY;
          state_d = S_OUT;
        end
      end
      S_MTST: begin
        if (stat_i.at_root) begin
          cmd_o   = CMD_RES_FREED;
          state_d = S_OUT;
        end else begin
          cmd_o   = CMD_BUDDY;
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        cmd_o   = CMD_RD;
        state_d = S_MEV;
      end
      S_MEV: begin
        if (stat_i.bit_busy) begin
          cmd_o   = CMD_RES_FREED;
          state_d = S_OUT;
        end else begin
          cmd_o   = CMD_PARENT;
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        cmd_o   = CMD_RD;
        state_d = S_PWR;
      end
      S_PWR: begin
        cmd_o   = CMD_WR_ONE;
        state_d = S_MTST;
      end
      S_OUT: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  `BBA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_o, !req_ready_o)
  `BBA_ASSERT_NOW(a_idle_no_result, clk_i, rst_ni, state_q == S_IDLE, !rsp_valid_o)
  `BBA_ASSERT_NEXT(a_ready_after_transfer, clk_i, rst_ni, rsp_valid_o && rsp_ready_i, req_ready_o)
  `BBA_ASSERT_NOW(a_clear_blocks, clk_i, rst_ni, state_q == S_CLEAR, cmd_o == CMD_CLR && !req_ready_o)

endmodule

// ===== sv/buddy_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy bitmap allocator
// Busy-bit tree buddy allocator with allocate and free requests.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset a clearing pass zeroes the
// busy-bit memory row by row while no request is taken. The busy bits sit in
// a single-port memory of 32-bit rows, and a row that is changed is read and
// then written back. An allocate searches for the level of the size, scans
// the rows of that level for a free bit, marks the subtree rows and then the
// ancestors; a free clears the subtree rows and then merges with free buddies
// level by level. Configuration writes are always taken.
module buddy_bitmap_allocator #(
  parameter int unsigned MAX_DEPTH = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bba_req_if.sink    req_i,
  bba_rsp_if.source  rsp_o,
  bba_cfg_if.sink    cfg_i
);
  import bba_pkg::*;

  cmd_e     cmd;
  dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bba_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_i.valid),
    .cfg_idx_i        (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .kind_i           (req_i.kind),
    .request_size_i   (req_i.request_size),
    .free_node_i      (req_i.free_node),
    .status_o         (rsp_o.status),
    .node_index_o     (rsp_o.node_index),
    .block_level_o    (rsp_o.block_level),
    .payload_offset_o (rsp_o.payload_offset)
  );

endmodule
